[rtl/shp_pkg.sv]
// Shared types and constants for the slice header parser.
package shp_pkg;

    localparam int unsigned ValueWidth = 33;
    localparam int unsigned IdWidth = 4;

    // Field ids
    localparam logic [3:0] FidFirstMb  = 4'd0;
    localparam logic [3:0] FidType     = 4'd1;
    localparam logic [3:0] FidPps      = 4'd2;
    localparam logic [3:0] FidPlane    = 4'd3;
    localparam logic [3:0] FidFrame    = 4'd4;
    localparam logic [3:0] FidField    = 4'd5;
    localparam logic [3:0] FidBottom   = 4'd6;
    localparam logic [3:0] FidIdr      = 4'd7;
    localparam logic [3:0] FidPoc      = 4'd8;
    localparam logic [3:0] FidDpoc     = 4'd9;
    localparam logic [3:0] FidNoOut    = 4'd10;
    localparam logic [3:0] FidLongTerm = 4'd11;
    localparam logic [3:0] FidQp       = 4'd12;
    localparam logic [3:0] FidLength   = 4'd13;
    localparam logic [3:0] FidError    = 4'd14;

    // Configuration register indexes
    localparam logic [2:0] CfgSepPlanes = 3'd0;
    localparam logic [2:0] CfgLog2Frame = 3'd1;
    localparam logic [2:0] CfgFrameMbs  = 3'd2;
    localparam logic [2:0] CfgPocType   = 3'd3;
    localparam logic [2:0] CfgLog2Poc   = 3'd4;
    localparam logic [2:0] CfgBotPres   = 3'd5;

    localparam logic [2:0] NalIdr = 3'd5;

    // One queued byte beat from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       idr;
    } byte_beat_t;

    // One result beat
    typedef struct packed {
        logic [IdWidth-1:0]    id;
        logic [ValueWidth-1:0] value;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic       sep_planes;
        logic [4:0] log2_frame;
        logic       frame_mbs;
        logic [1:0] poc_type;
        logic [4:0] log2_poc;
        logic       bot_pres;
    } cfg_t;

    function automatic logic is_golomb(input logic [3:0] s);
        return (s == FidFirstMb) || (s == FidType) || (s == FidPps) ||
               (s == FidIdr) || (s == FidDpoc) || (s == FidQp);
    endfunction

    function automatic logic [4:0] clamp_width(input logic [4:0] v);
        if (v < 5'd4)
            return 5'd4;
        if (v > 5'd16)
            return 5'd16;
        return v;
    endfunction

endpackage

[rtl/shp_fifo.sv]
// Small register queue used between the byte front end and the bit engine
// and for the result output.
module shp_fifo #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [Width-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [Width-1:0] rd_data,
    output logic             empty,
    output logic [$clog2(Depth+1)-1:0] count
);
    localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

    logic [Width-1:0] mem_reg [Depth];
    logic [AddrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(Depth+1)-1:0] count_reg;

    assign full    = (count_reg == ($clog2(Depth+1))'(Depth));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

    // Storage, no reset on payload
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en && !full)
                wr_ptr_reg <= (wr_ptr_reg == AddrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en && !empty)
                rd_ptr_reg <= (rd_ptr_reg == AddrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + ($clog2(Depth+1))'(wr_en && !full)
                                   - ($clog2(Depth+1))'(rd_en && !empty);
        end
    end
endmodule

[rtl/shp_engine.sv]
// Bit-serial back end: one header bit per cycle unless stalled; emits field results.
module shp_engine #(
    parameter int unsigned MaxLeadingZeros = 31,
    parameter int unsigned MaxHeaderBytes  = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  shp_pkg::cfg_t       cfg,
    input  logic                in_valid,
    input  shp_pkg::byte_beat_t in_beat,
    output logic                in_take,
    output logic                res_valid,
    output shp_pkg::result_t    res,
    input  logic [1:0]          res_space
);
    import shp_pkg::*;

    localparam int unsigned BitsW = $clog2(MaxHeaderBytes * 8 + 1);
    localparam logic [BitsW-1:0] MaxBits = BitsW'(MaxHeaderBytes * 8);

    logic [7:0]       sh_reg, sh_next;
    logic [3:0]       left_reg, left_next;       // bits of current byte left
    logic [3:0]       step_reg, step_next;
    logic [5:0]       lz_reg, lz_next;
    logic [32:0]      acc_reg, acc_next;
    logic [BitsW-1:0] bits_reg, bits_next;
    logic [4:0]       bleft_reg, bleft_next;
    logic             fps_reg, fps_next;
    logic             idr_reg, idr_next;
    logic             done_reg, done_next;
    logic [2:0]       m5_reg, m5_next;           // accumulator modulo five

    // Two result slots per bit at most (field plus length or error)
    logic             emit0, emit1;
    result_t          r0, r1;
    logic             phase_reg, phase_next; // second result pending
    result_t          pend_reg, pend_next;

    function automatic logic present(input logic [3:0] s, input cfg_t c, input logic fps,
                                     input logic idr);
        case (s)
            FidPlane:                          return c.sep_planes;
            FidField:                          return !c.frame_mbs;
            FidBottom:                         return fps;
            FidIdr, FidNoOut, FidLongTerm:     return idr;
            FidPoc:                            return c.poc_type == 2'd0;
            FidDpoc: return (c.poc_type == 2'd0) && !fps && c.bot_pres;
            default:                           return 1'b1;
        endcase
    endfunction

    function automatic logic [4:0] fwidth(input logic [3:0] s, input cfg_t c);
        if (s == FidPlane)
            return 5'd2;
        if (s == FidFrame)
            return clamp_width(c.log2_frame);
        if (s == FidPoc)
            return clamp_width(c.log2_poc);
        return 5'd1;
    endfunction

    // Skip absent fields; at most a handful of narrow steps
    function automatic logic [3:0] next_present(input logic [3:0] s, input cfg_t c,
                                                input logic fps, input logic idr);
        logic [3:0] t;
        t = s;
        for (int k = 0; k < 12; k++)
        begin
            if (t < FidQp && !present(t, c, fps, idr))
                t = t + 4'd1;
        end
        return t;
    endfunction

    logic       busy;
    logic       bit_go;
    logic       b;
    logic [3:0] ent_s;
    logic [32:0] val;
    logic        fdone;
    logic [BitsW-1:0] bits_inc;
    logic [3:0]  m5_dbl;
    logic [2:0]  m5_shift;
    logic [32:0] type_mod;

    assign busy    = (left_reg != 4'd0);
    // Accept a new byte when current is exhausted and no second result is pending
    assign in_take = in_valid && !busy && !phase_reg;
    assign bit_go  = busy && !phase_reg && (res_space >= 2'd2);
    assign b       = sh_reg[7];
    assign bits_inc = bits_reg + 1'b1;

    // Slice type modulo five, tracked one suffix bit at a time
    assign m5_dbl   = {m5_reg, b};
    assign m5_shift = (m5_dbl >= 4'd5) ? 3'(m5_dbl - 4'd5) : m5_dbl[2:0];
    assign type_mod = (m5_shift == 3'd0) ? 33'd4 : 33'(m5_shift - 3'd1);

    always_comb
    begin
        sh_next    = sh_reg;
        left_next  = left_reg;
        step_next  = step_reg;
        lz_next    = lz_reg;
        acc_next   = acc_reg;
        bits_next  = bits_reg;
        bleft_next = bleft_reg;
        fps_next   = fps_reg;
        idr_next   = idr_reg;
        done_next  = done_reg;
        m5_next    = m5_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        emit0 = 1'b0;
        emit1 = 1'b0;
        r0 = '0;
        r1 = '0;
        val = '0;
        fdone = 1'b0;
        ent_s = '0;

        if (phase_reg)
        begin
            if (res_space >= 2'd1)
            begin
                emit0 = 1'b1;
                r0 = pend_reg;
                phase_next = 1'b0;
            end
        end
        else if (in_take)
        begin
            sh_next   = in_beat.data;
            left_next = 4'd8;
            if (in_beat.start)
            begin
                idr_next   = in_beat.idr;
                fps_next   = 1'b0;
                bits_next  = '0;
                done_next  = 1'b0;
                ent_s      = next_present(FidFirstMb, cfg, 1'b0, in_beat.idr);
                step_next  = ent_s;
                lz_next    = '0;
                acc_next   = '0;
                m5_next    = 3'd0;
                bleft_next = is_golomb(ent_s) ? 5'd0 : fwidth(ent_s, cfg);
            end
        end
        else if (bit_go)
        begin
            sh_next   = {sh_reg[6:0], 1'b0};
            left_next = left_reg - 4'd1;
            if (!done_reg)
            begin
                bits_next = bits_inc;
                if (!is_golomb(step_reg) || bleft_reg != 5'd0)
                begin
                    acc_next   = {acc_reg[31:0], b};
                    m5_next    = m5_shift;
                    bleft_next = bleft_reg - 5'd1;
                    if (bleft_reg == 5'd1)
                    begin
                        fdone = 1'b1;
                        val = is_golomb(step_reg) ? acc_next - 33'd1 : acc_next;
                    end
                end
                else if (!b)
                begin
                    if (lz_reg >= 6'(MaxLeadingZeros))
                    begin
                        emit0 = 1'b1;
                        r0 = '{id: FidError, value: 33'(bits_inc), last: 1'b1};
                        done_next = 1'b1;
                    end
                    else
                        lz_next = lz_reg + 6'd1;
                end
                else if (lz_reg == 6'd0)
                    fdone = 1'b1;
                else
                begin
                    bleft_next = 5'(lz_reg);
                    acc_next   = 33'd1;
                    m5_next    = 3'd1;
                end

                if (fdone)
                begin
                    // single-bit code is zero; otherwise take the tracked residue
                    if (step_reg == FidType)
                        val = (bleft_reg == 5'd0) ? 33'd0 : type_mod;
                    if (step_reg == FidDpoc || step_reg == FidQp)
                        val = val[0] ? ((val + 33'd1) >> 1) : (33'd0 - (val >> 1));
                    emit0 = 1'b1;
                    r0 = '{id: step_reg, value: val, last: 1'b0};
                    if (step_reg == FidField)
                        fps_next = val[0];
                    if (step_reg >= FidQp)
                    begin
                        emit1 = 1'b1;
                        r1 = '{id: FidLength, value: 33'(bits_inc), last: 1'b1};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        ent_s = next_present(step_reg + 4'd1, cfg, fps_next, idr_reg);
                        step_next  = ent_s;
                        lz_next    = '0;
                        acc_next   = '0;
                        m5_next    = 3'd0;
                        bleft_next = is_golomb(ent_s) ? 5'd0 : fwidth(ent_s, cfg);
                    end
                end

                if (!done_next && bits_inc >= MaxBits)
                begin
                    emit1 = 1'b1;
                    r1 = '{id: FidError, value: 33'(bits_inc), last: 1'b1};
                    done_next = 1'b1;
                end
            end
            // a lone second result goes out now; a pair's second goes out next cycle
            if (emit1 && !emit0)
            begin
                emit0 = 1'b1;
                r0 = r1;
            end
            else if (emit1)
            begin
                phase_next = 1'b1;
                pend_next  = r1;
            end
        end
    end

    assign res_valid = emit0;
    assign res       = r0;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            step_reg  <= '0;
            lz_reg    <= '0;
            acc_reg   <= '0;
            bits_reg  <= '0;
            bleft_reg <= '0;
            fps_reg   <= 1'b0;
            idr_reg   <= 1'b0;
            done_reg  <= 1'b1;
            m5_reg    <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            left_reg  <= left_next;
            step_reg  <= step_next;
            lz_reg    <= lz_next;
            acc_reg   <= acc_next;
            bits_reg  <= bits_next;
            bleft_reg <= bleft_next;
            fps_reg   <= fps_next;
            idr_reg   <= idr_next;
            done_reg  <= done_next;
            m5_reg    <= m5_next;
            phase_reg <= phase_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        pend_reg <= pend_next;
    end
endmodule

[rtl/slice_header_parser.sv]
// Top level of the slice header parser.
//
// Usage: slice bytes enter on the push/full queue port, one beat per byte,
// slice_start set on the first byte of a slice (nal_unit_type sampled there).
// Parsed fields leave on the empty/pop queue port as (field_id, field_value)
// beats; the header length (or an error) ends each header with
// last_of_header set. The user must write registers on cfg_valid/cfg_ready
// only while idle; the block itself does not enforce this. The bit engine
// loads a byte, then shifts it out one bit per cycle while result space
// allows, and takes no new byte until the current one is spent; a bit that
// ends both a field and the header emits the closing beat on its own, while
// shifting waits. Bytes queue in a 4-entry input queue, results in an 8-entry
// output queue, so input keeps flowing while the receiver stalls; when the
// result queue nears full the engine pauses and the input queue then fills
// and raises full.
// Reset empties both queues, puts the registers at their defaults and leaves
// the parser idle until a slice start.
module slice_header_parser #(
    parameter int unsigned MAX_LEADING_ZEROS = 31,
    parameter int unsigned MAX_HEADER_BYTES  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        slice_start,
    input  logic [4:0]  nal_unit_type,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  field_id,
    output logic signed [32:0] field_value,
    output logic        last_of_header,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    import shp_pkg::*;

    cfg_t       cfg_reg;
    byte_beat_t in_beat, q_beat;
    logic       q_empty, q_full, take, res_valid;
    result_t    res, out_res;
    logic [3:0] oq_count;
    logic [2:0] iq_count;
    logic [1:0] space;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{sep_planes: 1'b0, log2_frame: 5'd4, frame_mbs: 1'b1,
                         poc_type: 2'd0, log2_poc: 5'd4, bot_pres: 1'b0};
        else if (cfg_valid)
        begin
            case (cfg_index)
                CfgSepPlanes: cfg_reg.sep_planes <= cfg_data[0];
                CfgLog2Frame: cfg_reg.log2_frame <= cfg_data;
                CfgFrameMbs:  cfg_reg.frame_mbs  <= cfg_data[0];
                CfgPocType:   cfg_reg.poc_type   <= cfg_data[1:0];
                CfgLog2Poc:   cfg_reg.log2_poc   <= cfg_data;
                CfgBotPres:   cfg_reg.bot_pres   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front: classify the beat (IDR flag) and queue it
    assign in_beat = '{data: data_byte, start: slice_start,
                       idr: (nal_unit_type == {2'b00, NalIdr})};
    assign full = q_full;

    shp_fifo #(.Width($bits(byte_beat_t)), .Depth(4)) u_in_q (
        .clk(clk), .rst_n(rst_n),
        .wr_en(push), .wr_data(in_beat), .full(q_full),
        .rd_en(take), .rd_data(q_beat), .empty(q_empty), .count(iq_count)
    );

    // Free result slots seen by the engine, saturated at two
    assign space = (oq_count <= 4'd6) ? 2'd2 : ((oq_count == 4'd7) ? 2'd1 : 2'd0);

    shp_engine #(.MaxLeadingZeros(MAX_LEADING_ZEROS),
                 .MaxHeaderBytes(MAX_HEADER_BYTES)) u_engine (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(!q_empty && (iq_count != 3'd0)), .in_beat(q_beat), .in_take(take),
        .res_valid(res_valid), .res(res), .res_space(space)
    );

    shp_fifo #(.Width($bits(result_t)), .Depth(8)) u_out_q (
        .clk(clk), .rst_n(rst_n),
        .wr_en(res_valid), .wr_data(res), .full(),
        .rd_en(pop), .rd_data(out_res), .empty(empty), .count(oq_count)
    );

    assign field_id       = out_res.id;
    assign field_value    = out_res.value;
    assign last_of_header = out_res.last;
endmodule

[dv/shp_checker.sv]
// Checker for the slice header parser: tracks beats, predicts results and compares them.
module shp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        slice_start,
    input  logic [4:0]  nal_unit_type,
    input  logic        empty,
    input  logic        pop,
    input  logic [3:0]  field_id,
    input  logic signed [32:0] field_value,
    input  logic        last_of_header,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    output int          pending,
    output int          fail_count
);
    import shp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LzLimit  = 31;
    localparam int unsigned BitLimit = 256 * 8;

    // Shadow registers
    logic       sep_planes;
    logic [4:0] log2_frame;
    logic       frame_mbs;
    logic [1:0] poc_type;
    logic [4:0] log2_poc;
    logic       bot_pres;

    // Shadow parse state
    logic [3:0]  step;
    int unsigned zeros;
    logic [32:0] acc;
    int unsigned consumed;
    int unsigned bits_left;
    logic        field_pic;
    logic        idr_slice;
    logic        parse_done;

    result_t field_q[$];

    task automatic report(input string what, input logic [32:0] got, input logic [32:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        fail_count++;
    endtask

    function automatic logic ue_field(input logic [3:0] s);
        return s == FidFirstMb || s == FidType || s == FidPps || s == FidIdr ||
               s == FidDpoc || s == FidQp;
    endfunction

    function automatic int unsigned width_of(input logic [4:0] v);
        return (v < 5'd4) ? 4 : (v > 5'd16) ? 16 : int'(v);
    endfunction

    function automatic logic field_present(input logic [3:0] s);
        case (s)
            FidPlane:  return sep_planes;
            FidField:  return !frame_mbs;
            FidBottom: return field_pic;
            FidIdr, FidNoOut, FidLongTerm: return idr_slice;
            FidPoc:    return poc_type == 2'd0;
            FidDpoc:   return poc_type == 2'd0 && !field_pic && bot_pres;
            default:   return 1'b1;
        endcase
    endfunction

    task automatic start_field(input logic [3:0] s);
        while (s < FidQp && !field_present(s))
            s++;
        step = s;
        zeros = 0;
        acc = '0;
        if (ue_field(s))
            bits_left = 0;
        else if (s == FidPlane)
            bits_left = 2;
        else if (s == FidFrame)
            bits_left = width_of(log2_frame);
        else if (s == FidPoc)
            bits_left = width_of(log2_poc);
        else
            bits_left = 1;
    endtask

    task automatic queue_field(input logic [3:0] id, input logic [32:0] v, input logic last);
        result_t r;
        r.id = id;
        r.value = v;
        r.last = last;
        field_q.push_back(r);
    endtask

    // One payload bit through the field decoder
    task automatic take_bit(input logic b);
        logic        done;
        logic [32:0] v;
        done = 1'b0;
        v = '0;
        consumed++;
        if (!ue_field(step) || bits_left != 0) begin
            acc = {acc[31:0], b};
            bits_left--;
            if (bits_left == 0) begin
                done = 1'b1;
                v = ue_field(step) ? acc - 33'd1 : acc;
            end
        end else if (!b) begin
            if (zeros >= LzLimit) begin
                queue_field(FidError, 33'(consumed), 1'b1);
                parse_done = 1'b1;
                return;
            end
            zeros++;
        end else if (zeros == 0) begin
            done = 1'b1;
        end else begin
            bits_left = zeros;
            acc = 33'd1;
        end

        if (done) begin
            if (step == FidType)
                v = v % 33'd5;
            if (step == FidDpoc || step == FidQp)
                v = v[0] ? (v + 33'd1) >> 1 : 33'd0 - (v >> 1);
            queue_field(step, v, 1'b0);
            if (step == FidField)
                field_pic = v[0];
            if (step >= FidQp) begin
                queue_field(FidLength, 33'(consumed), 1'b1);
                parse_done = 1'b1;
                return;
            end
            start_field(step + 4'd1);
        end

        if (consumed >= BitLimit) begin
            queue_field(FidError, 33'(consumed), 1'b1);
            parse_done = 1'b1;
        end
    endtask

    task automatic take_byte(input logic [7:0] d, input logic st, input logic [4:0] nt);
        if (st) begin
            idr_slice = nt == 5'd5;
            field_pic = 1'b0;
            consumed = 0;
            parse_done = 1'b0;
            start_field(FidFirstMb);
        end
        for (int i = 7; i >= 0 && !parse_done; i--)
            take_bit(d[i]);
    endtask

    // Beat monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sep_planes = 1'b0;
            log2_frame = 5'd4;
            frame_mbs = 1'b1;
            poc_type = 2'd0;
            log2_poc = 5'd4;
            bot_pres = 1'b0;
            step = '0;
            zeros = 0;
            acc = '0;
            consumed = 0;
            bits_left = 0;
            field_pic = 1'b0;
            idr_slice = 1'b0;
            parse_done = 1'b1;
            field_q.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CfgSepPlanes: sep_planes = cfg_data[0];
                    CfgLog2Frame: log2_frame = cfg_data;
                    CfgFrameMbs:  frame_mbs = cfg_data[0];
                    CfgPocType:   poc_type = cfg_data[1:0];
                    CfgLog2Poc:   log2_poc = cfg_data;
                    CfgBotPres:   bot_pres = cfg_data[0];
                    default: ;
                endcase
            end
            if (push && !full)
                take_byte(data_byte, slice_start, nal_unit_type);
            if (pop && !empty) begin
                if (field_q.size() == 0) begin
                    report("unexpected beat, id", 33'(field_id), '0);
                end else begin
                    result_t want;
                    want = field_q.pop_front();
                    if (field_id !== want.id)
                        report("field_id", 33'(field_id), 33'(want.id));
                    if (field_value !== want.value)
                        report("field_value", field_value, want.value);
                    if (last_of_header !== want.last)
                        report("last_of_header", 33'(last_of_header), 33'(want.last));
                end
            end
            pending = field_q.size();
        end
    end

endmodule

[dv/tb_top.sv]
// Top of the slice header parser testbench: clock, reset, stimulus and verdict.
module tb_top;
    import shp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 5000;
    localparam int SettleCycles = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = '0;
    logic        slice_start = 1'b0;
    logic [4:0]  nal_unit_type = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  field_id;
    logic signed [32:0] field_value;
    logic        last_of_header;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;

    int pending;
    int fail_count;
    int tx_idle = 17;
    int rx_idle = 66;
    int byte_count = 0;
    int stall = 0;

    // Register values as last written
    logic       sh_sep = 1'b0;
    logic [4:0] sh_frame = 5'd4;
    logic       sh_fmbs = 1'b1;
    logic [1:0] sh_poct = 2'd0;
    logic [4:0] sh_poc = 5'd4;
    logic       sh_bot = 1'b0;

    bit hdr_bits[$];

    always #5 clk = ~clk;

    slice_header_parser u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .data_byte(data_byte),
        .slice_start(slice_start), .nal_unit_type(nal_unit_type), .empty(empty), .pop(pop),
        .field_id(field_id), .field_value(field_value), .last_of_header(last_of_header),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    shp_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .data_byte(data_byte),
        .slice_start(slice_start), .nal_unit_type(nal_unit_type), .empty(empty), .pop(pop),
        .field_id(field_id), .field_value(field_value), .last_of_header(last_of_header),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pending(pending), .fail_count(fail_count)
    );

    // Receiver: random pop
    always @(posedge clk)
        pop <= $urandom_range(99) >= rx_idle;

    // Watchdog on cycles with no beat at all
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall <= 0;
        else
            stall <= stall + 1;
        if (stall >= StallLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic st, input logic [4:0] nt);
        bit took;
        while ($urandom_range(99) < tx_idle) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= d;
        slice_start <= st;
        nal_unit_type <= nt;
        do begin
            @(negedge clk);
            took = !full;
            @(posedge clk);
        end while (!took);
        byte_count++;
        if (byte_count < 75) begin
            tx_idle = 17;
            rx_idle = 66;
        end else if (byte_count < 150) begin
            tx_idle = 66;
            rx_idle = 17;
        end else begin
            tx_idle = 0;
            rx_idle = 0;
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [4:0] d);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end while (!took);
    endtask

    // Idle the block, then write every register
    task automatic set_regs(input logic sp, input logic [4:0] lf, input logic fm,
                            input logic [1:0] pt, input logic [4:0] lp, input logic bp);
        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        write_cfg(CfgSepPlanes, {4'd0, sp});
        write_cfg(CfgLog2Frame, lf);
        write_cfg(CfgFrameMbs, {4'd0, fm});
        write_cfg(CfgPocType, {3'd0, pt});
        write_cfg(CfgLog2Poc, lp);
        write_cfg(CfgBotPres, {4'd0, bp});
        cfg_valid <= 1'b0;
        {sh_sep, sh_frame, sh_fmbs, sh_poct, sh_poc, sh_bot} = {sp, lf, fm, pt, lp, bp};
    endtask

    function automatic longint unsigned pick_code();
        int nb;
        nb = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(4);
        return longint'($urandom) & ((64'd1 << nb) - 1);
    endfunction

    // Exp-Golomb code of v into the bit queue
    task automatic add_ue(input longint unsigned v);
        longint unsigned x;
        int n;
        x = v + 1;
        n = 0;
        while ((x >> (n + 1)) != 0)
            n++;
        repeat (n) hdr_bits.push_back(1'b0);
        for (int i = n; i >= 0; i--)
            hdr_bits.push_back(x[i]);
    endtask

    task automatic add_bits(input int n);
        repeat (n) hdr_bits.push_back(1'($urandom_range(1)));
    endtask

    function automatic int clamp4_16(input logic [4:0] v);
        return (v < 5'd4) ? 4 : (v > 5'd16) ? 16 : int'(v);
    endfunction

    // A header built for the current registers, cut short when broken
    task automatic send_slice(input bit broken);
        logic [4:0] nt;
        bit fpic;
        logic [7:0] b;
        nt = $urandom_range(1) ? 5'd5 : 5'($urandom_range(31));
        hdr_bits.delete();
        repeat (3) add_ue(pick_code());
        if (sh_sep)
            add_bits(2);
        add_bits(clamp4_16(sh_frame));
        fpic = 1'b0;
        if (!sh_fmbs) begin
            fpic = $urandom_range(1);
            hdr_bits.push_back(fpic);
            if (fpic)
                add_bits(1);
        end
        if (nt == 5'd5)
            add_ue(pick_code());
        if (sh_poct == 2'd0) begin
            add_bits(clamp4_16(sh_poc));
            if (sh_bot && !fpic)
                add_ue(pick_code());
        end
        if (nt == 5'd5)
            add_bits(2);
        add_ue(pick_code());
        if (broken)
            hdr_bits = hdr_bits[0:$urandom_range(hdr_bits.size() - 1)];
        add_bits($urandom_range(20));
        while (hdr_bits.size() % 8 != 0)
            add_bits(1);
        for (int i = 0; i < hdr_bits.size(); i += 8) begin
            for (int j = 0; j < 8; j++)
                b[7 - j] = hdr_bits[i + j];
            send_byte(b, i == 0, (i == 0) ? nt : 5'($urandom_range(31)));
        end
    endtask

    task automatic random_phase(input int n_bytes);
        int stop;
        stop = byte_count + n_bytes;
        while (byte_count < stop) begin
            case ($urandom_range(9))
                0: send_slice(1'b1);
                1: send_byte(8'($urandom), 1'b0, 5'($urandom_range(31)));
                default: send_slice(1'b0);
            endcase
        end
        send_slice(1'b0);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all-ones codes, over-long code, restart mid-header, idle bytes
        send_byte(8'hFF, 1'b1, 5'd5);
        send_byte(8'hFF, 1'b0, 5'd0);
        send_byte(8'h00, 1'b1, 5'd1);
        send_byte(8'h00, 1'b0, 5'd0);
        send_byte(8'h00, 1'b0, 5'd0);
        send_byte(8'h00, 1'b0, 5'd0);
        send_byte(8'h00, 1'b0, 5'd0);
        send_byte(8'h00, 1'b1, 5'd31);
        send_byte(8'hFF, 1'b1, 5'd10);
        send_byte(8'hFF, 1'b0, 5'd0);
        send_byte(8'hAA, 1'b0, 5'd21);
        send_byte(8'h55, 1'b0, 5'd0);
        repeat (4) send_slice(1'b0);

        // Every optional field enabled, widest fixed fields
        set_regs(1'b1, 5'd16, 1'b0, 2'd0, 5'd16, 1'b1);
        repeat (3) send_slice(1'b0);
        random_phase(20);

        // Narrowest widths, no order count lsb
        set_regs(1'b0, 5'd0, 1'b1, 2'd2, 5'd4, 1'b0);
        random_phase(10);
        wait_drained();
        random_phase(10);

        // Out-of-range widths clamp (order count width unused with poc_type 1)
        set_regs(1'b1, 5'd31, 1'b0, 2'd1, 5'd3, 1'b1);
        random_phase(20);

        repeat (2) begin
            set_regs(1'($urandom), 5'($urandom_range(4, 16)), 1'($urandom),
                     2'($urandom_range(2)), 5'($urandom_range(4, 16)), 1'($urandom));
            random_phase(20);
        end

        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[slice_header_parser.f]
rtl/shp_pkg.sv
rtl/shp_fifo.sv
rtl/shp_engine.sv
rtl/slice_header_parser.sv
dv/shp_checker.sv
dv/tb_top.sv
